// ----- hdl/npcm_pkg.sv -----
// Shared types and constants for the nearest palette colour match block.
// No dependencies; imported by every module of the block except npcm_ram.
package npcm_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int CH_W            = 8;
    localparam int ENTRY_W         = 3 * CH_W;
    localparam int FIELD_IDX_W     = 8;
    localparam int DIST_W          = 10;

    localparam logic [DIST_W-1:0] DIST_START = DIST_W'(1000);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic start;
        logic write;
        logic scan;
        logic emit;
    } npcm_cmd_t;

    typedef struct packed {
        logic done;
        logic out_free;
    } npcm_stat_t;

endpackage

// ----- hdl/npcm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module npcm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/npcm_ctrl.sv -----
// Controller state machine: accepts words, sequences the palette scan and
// hands the result to the output register. Depends on npcm_pkg.
module npcm_ctrl import npcm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    output logic       s_tready,
    output npcm_cmd_t  cmd,
    input  npcm_stat_t stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd.write = accept && (s_tuser == FUNC_WRITE);
        cmd.start = accept && (s_tuser == FUNC_QUERY);
        cmd.scan  = (state_reg == ST_SCAN);
        cmd.emit  = (state_reg == ST_FIN) && stat.out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (cmd.emit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && stat.done) |=> (state_reg == ST_FIN))
        else $error("scan completion did not move to result hand-off");
    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_FIN) |-> !s_tready)
        else $error("input ready while a query is in progress");
`endif

endmodule

// ----- hdl/npcm_datapath.sv -----
// Datapath: palette store with valid bits, scan address generator, distance
// compare, best-match registers and the output register. Depends on npcm_pkg
// and npcm_ram.
module npcm_datapath import npcm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  npcm_cmd_t              cmd,
    output npcm_stat_t             stat,
    input  logic [FIELD_IDX_W-1:0] entry_index,
    input  logic [CH_W-1:0]        red,
    input  logic [CH_W-1:0]        green,
    input  logic [CH_W-1:0]        blue,
    input  logic                   exclude_enable,
    input  logic [FIELD_IDX_W-1:0] exclude_index,
    output logic                   m_valid,
    input  logic                   m_tready,
    output logic [FIELD_IDX_W-1:0] m_best_index,
    output logic                   m_exact_hit
);

    logic [PALETTE_ENTRIES-1:0] valid_reg;

    logic [CH_W-1:0]        q_red_reg;
    logic [CH_W-1:0]        q_green_reg;
    logic [CH_W-1:0]        q_blue_reg;
    logic                   q_excl_en_reg;
    logic [FIELD_IDX_W-1:0] q_excl_idx_reg;

    logic             issue_active_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic             rd_pend_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_last_reg;
    logic             ent_valid_reg;

    logic [DIST_W-1:0] best_dist_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic              hit_reg;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [FIELD_IDX_W-1:0] m_best_reg;
    logic                   m_hit_reg;

    logic               wr_in_range;
    logic               wr_en;
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] entry;
    logic [CH_W-1:0]    e_red;
    logic [CH_W-1:0]    e_green;
    logic [CH_W-1:0]    e_blue;
    logic [CH_W-1:0]    d_red;
    logic [CH_W-1:0]    d_green;
    logic [CH_W-1:0]    d_blue;
    logic [CH_W-1:0]    d_max;
    logic               eval;
    logic               skip;
    logic               exact;
    logic               closer;

    assign wr_in_range = ({1'b0, entry_index} < (FIELD_IDX_W + 1)'(PALETTE_ENTRIES));
    assign wr_en       = cmd.write && wr_in_range;

    npcm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (entry_index[IDX_W-1:0]),
        .wdata ({red, green, blue}),
        .raddr (rd_addr_reg),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[entry_index[IDX_W-1:0]] <= 1'b1;
        end
    end

    always_comb begin
        entry   = ent_valid_reg ? rd_data : '0;
        e_red   = entry[3*CH_W-1:2*CH_W];
        e_green = entry[2*CH_W-1:CH_W];
        e_blue  = entry[CH_W-1:0];
        d_red   = (e_red   > q_red_reg)   ? (e_red   - q_red_reg)   : (q_red_reg   - e_red);
        d_green = (e_green > q_green_reg) ? (e_green - q_green_reg) : (q_green_reg - e_green);
        d_blue  = (e_blue  > q_blue_reg)  ? (e_blue  - q_blue_reg)  : (q_blue_reg  - e_blue);
        d_max   = d_red;
        if (d_green > d_max) begin
            d_max = d_green;
        end
        if (d_blue > d_max) begin
            d_max = d_blue;
        end
        eval   = cmd.scan && rd_pend_reg;
        skip   = q_excl_en_reg && (FIELD_IDX_W'(rd_idx_reg) == q_excl_idx_reg);
        exact  = eval && !skip && (d_max == '0);
        closer = eval && !skip && (DIST_W'(d_max) < best_dist_reg);
    end

    assign stat.done     = exact || (eval && rd_last_reg);
    assign stat.out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            q_red_reg      <= red;
            q_green_reg    <= green;
            q_blue_reg     <= blue;
            q_excl_en_reg  <= exclude_enable;
            q_excl_idx_reg <= exclude_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_active_reg <= 1'b0;
            rd_addr_reg      <= '0;
            rd_pend_reg      <= 1'b0;
            rd_idx_reg       <= '0;
            rd_last_reg      <= 1'b0;
            ent_valid_reg    <= 1'b0;
        end else if (cmd.start) begin
            issue_active_reg <= 1'b1;
            rd_addr_reg      <= IDX_W'(PALETTE_ENTRIES - 1);
            rd_pend_reg      <= 1'b0;
        end else if (cmd.scan) begin
            rd_pend_reg <= issue_active_reg;
            if (issue_active_reg) begin
                rd_idx_reg    <= rd_addr_reg;
                rd_last_reg   <= (rd_addr_reg == '0);
                ent_valid_reg <= valid_reg[rd_addr_reg];
                rd_addr_reg   <= rd_addr_reg - 1'b1;
                if (rd_addr_reg == '0) begin
                    issue_active_reg <= 1'b0;
                end
            end
        end else begin
            rd_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_dist_reg <= DIST_START;
            best_idx_reg  <= '0;
            hit_reg       <= 1'b0;
        end else if (cmd.start) begin
            best_dist_reg <= DIST_START;
            best_idx_reg  <= '0;
            hit_reg       <= 1'b0;
        end else if (exact) begin
            best_idx_reg <= rd_idx_reg;
            hit_reg      <= 1'b1;
        end else if (closer) begin
            best_dist_reg <= DIST_W'(d_max);
            best_idx_reg  <= rd_idx_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_best_reg <= FIELD_IDX_W'(best_idx_reg);
            m_hit_reg  <= hit_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_best_index = m_best_reg;
    assign m_exact_hit  = m_hit_reg;

`ifndef NO_ASSERTIONS
    a_last_read_ends_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        (eval && rd_last_reg) |-> !issue_active_reg)
        else $error("reads still issued after the lowest entry");
    a_hit_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(hit_reg) |-> $past(cmd.scan))
        else $error("exact hit flagged outside a scan");
    a_dist_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (best_dist_reg < DIST_W'(256)) || (best_dist_reg == DIST_START))
        else $error("best distance outside channel range");
    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !cmd.emit)
        else $error("result loaded over an untaken result");
`endif

endmodule

// ----- hdl/nearest_palette_colour_match_top.sv -----
// Top level of the nearest palette colour match block: stream ports, the
// controller and the datapath. Depends on npcm_pkg, npcm_ctrl, npcm_datapath.
//
// A write word (tuser 0) stores one RGB palette entry; an index past the
// palette is dropped. A query word (tuser 1) scans the palette from the
// highest entry down, one entry per cycle through the single read port of
// the palette RAM, skips the excluded index when exclusion is enabled, and
// returns the index with the smallest largest channel difference, higher
// index on a tie, stopping early on an exact match. The palette reads as
// all zero after reset through per-entry valid bits, so no clearing pass
// is needed. A finished result waits in the output register while the
// next word is accepted.
module nearest_palette_colour_match_top import npcm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24],
    // exclude_enable[32], exclude_index[40:33], zero[47:41]
    input  logic [47:0] s_tdata,
    // func[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // best_index[7:0], exact_hit[8], zero[15:9]
    output logic [15:0] m_tdata
);

    npcm_cmd_t              cmd;
    npcm_stat_t             stat;
    logic [FIELD_IDX_W-1:0] best_index;
    logic                   exact_hit;

    npcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    npcm_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .entry_index    (s_tdata[7:0]),
        .red            (s_tdata[15:8]),
        .green          (s_tdata[23:16]),
        .blue           (s_tdata[31:24]),
        .exclude_enable (s_tdata[32]),
        .exclude_index  (s_tdata[40:33]),
        .m_valid        (m_tvalid),
        .m_tready       (m_tready),
        .m_best_index   (best_index),
        .m_exact_hit    (exact_hit)
    );

    assign m_tdata = {7'b0, exact_hit, best_index};

endmodule

// ----- tb/palette_match_checker.sv -----
// Checker for the nearest palette colour match block: keeps its own palette,
// predicts the answer to every accepted query word and compares result words.
// Depends on npcm_pkg.
module palette_match_checker import npcm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24],
    // exclude_enable[32], exclude_index[40:33], zero[47:41]
    input  logic [47:0] s_tdata,
    // func[0]
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // best_index[7:0], exact_hit[8], zero[15:9]
    input  logic [15:0] m_tdata,
    output int          mismatch_count,
    output int          matches_owed
);

    typedef struct packed {
        logic [FIELD_IDX_W-1:0] best_index;
        logic                   exact_hit;
    } match_t;

    logic [ENTRY_W-1:0] palette_copy [PALETTE_ENTRIES];
    match_t             owed_matches [$];
    int                 fails;

    function automatic logic [CH_W-1:0] channel_gap(input logic [CH_W-1:0] a,
                                                    input logic [CH_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic match_t nearest_match(input logic [ENTRY_W-1:0]     colour,
                                             input logic                   skip_en,
                                             input logic [FIELD_IDX_W-1:0] skip_idx);
        logic [DIST_W-1:0] best_dist;
        logic [CH_W-1:0]   spread;
        logic [CH_W-1:0]   gap;
        logic [ENTRY_W-1:0] entry;
        match_t            found;
        best_dist = DIST_START;
        found     = '0;
        for (int i = PALETTE_ENTRIES - 1; i >= 0 && !found.exact_hit; i--) begin
            if (!(skip_en && i == int'(skip_idx))) begin
                entry  = palette_copy[i];
                spread = channel_gap(entry[2*CH_W +: CH_W], colour[2*CH_W +: CH_W]);
                gap    = channel_gap(entry[CH_W +: CH_W], colour[CH_W +: CH_W]);
                if (gap > spread) spread = gap;
                gap    = channel_gap(entry[0 +: CH_W], colour[0 +: CH_W]);
                if (gap > spread) spread = gap;
                if (spread == '0) begin
                    found.best_index = FIELD_IDX_W'(i);
                    found.exact_hit  = 1'b1;
                end else if (DIST_W'(spread) < best_dist) begin
                    best_dist        = DIST_W'(spread);
                    found.best_index = FIELD_IDX_W'(i);
                end
            end
        end
        return found;
    endfunction

    always @(posedge aclk) begin : watch
        logic [ENTRY_W-1:0]     colour;
        logic [FIELD_IDX_W-1:0] got_idx;
        logic                   got_hit;
        match_t                 want;
        if (!aresetn) begin
            owed_matches.delete();
            for (int i = 0; i < PALETTE_ENTRIES; i++) palette_copy[i] = '0;
            fails = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                colour = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
                if (s_tuser == FUNC_WRITE) begin
                    if (int'(s_tdata[7:0]) < PALETTE_ENTRIES)
                        palette_copy[s_tdata[7:0]] = colour;
                end else begin
                    owed_matches.push_back(nearest_match(colour, s_tdata[32], s_tdata[40:33]));
                end
            end
            if (m_tvalid && m_tready) begin
                got_idx = m_tdata[7:0];
                got_hit = m_tdata[8];
                if (owed_matches.size() == 0) begin
                    $error("result word with no query outstanding: best_index %0d exact_hit %0d",
                           got_idx, got_hit);
                    fails++;
                end else begin
                    want = owed_matches.pop_front();
                    if (want.best_index !== got_idx) begin
                        $error("best_index mismatch: expected %0d, actual %0d",
                               want.best_index, got_idx);
                        fails++;
                    end
                    if (want.exact_hit !== got_hit) begin
                        $error("exact_hit mismatch: expected %0d, actual %0d",
                               want.exact_hit, got_hit);
                        fails++;
                    end
                end
            end
        end
        mismatch_count <= fails;
        matches_owed   <= owed_matches.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the nearest palette colour match block: clock, reset,
// palette writes and colour queries under idle and stall patterns, verdict.
// Depends on npcm_pkg, nearest_palette_colour_match_top, palette_match_checker.
module tb_top;
    import npcm_pkg::*;

    localparam int RANDOM_WORDS    = 245;
    localparam int HOLD_OFF_CYCLES = 2000;
    localparam int DRAIN_CYCLES    = 300;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    int          mismatch_count;
    int          matches_owed;
    int          phase_no      = 0;
    int          send_idle_pct = 30;
    logic        rx_hold       = 1'b0;
    logic [23:0] written_colour [256];

    nearest_palette_colour_match_top u_top (.*);

    palette_match_checker u_chk (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !rx_hold && ($urandom_range(0, 99) >=
                        (phase_no == 0 ? 70 : phase_no == 1 ? 30 : 0));
        end
    end

    // hold the result side off long enough for the block to back up
    initial begin
        wait (phase_no == 2);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic send_word(input logic        func,
                             input logic [7:0]  entry_idx,
                             input logic [23:0] colour,
                             input logic        skip_en,
                             input logic [7:0]  skip_idx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {7'b0, skip_idx, skip_en, colour[7:0], colour[15:8], colour[23:16],
                     entry_idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (func == FUNC_WRITE) written_colour[entry_idx] = colour;
    endtask

    task automatic random_words(input int count);
        logic [7:0]  pick;
        logic [23:0] colour;
        for (int k = 0; k < count; k++) begin
            pick = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 45) begin
                if ($urandom_range(0, 2) == 0)
                    colour = {8'($urandom_range(0, 3) * 85), 8'($urandom_range(0, 3) * 85),
                              8'($urandom_range(0, 3) * 85)};
                else
                    colour = 24'($urandom);
                send_word(FUNC_WRITE, pick, colour, 1'($urandom), 8'($urandom));
            end else begin
                case ($urandom_range(0, 3))
                    0, 1:    colour = written_colour[pick];
                    2:       colour = written_colour[pick] ^ (24'($urandom) & 24'h070707);
                    default: colour = 24'($urandom);
                endcase
                send_word(FUNC_QUERY, 8'($urandom), colour, 1'($urandom),
                          $urandom_range(0, 1) ? pick : 8'($urandom));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 256; i++) written_colour[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all-zero palette: exact hit at the top entry, ties on the far colour
        send_word(FUNC_QUERY, 8'd0,   24'h000000, 1'b0, 8'd0);
        send_word(FUNC_QUERY, 8'd255, 24'h000000, 1'b1, 8'd255);
        send_word(FUNC_QUERY, 8'd0,   24'hffffff, 1'b0, 8'd255);
        send_word(FUNC_QUERY, 8'd255, 24'hffffff, 1'b1, 8'd0);
        send_word(FUNC_WRITE, 8'd0,   24'hffffff, 1'b1, 8'd255);
        send_word(FUNC_WRITE, 8'd255, 24'h0a141e, 1'b0, 8'd0);
        send_word(FUNC_WRITE, 8'd128, 24'hff0080, 1'b1, 8'd0);
        send_word(FUNC_WRITE, 8'd127, 24'hff0080, 1'b0, 8'd255);
        // duplicate entries: exact hit keeps the higher index, excluded falls to the lower
        send_word(FUNC_QUERY, 8'd0,   24'hff0080, 1'b0, 8'd128);
        send_word(FUNC_QUERY, 8'd0,   24'hff0080, 1'b1, 8'd128);
        send_word(FUNC_QUERY, 8'd0,   24'hffffff, 1'b0, 8'd0);
        send_word(FUNC_QUERY, 8'd0,   24'hffffff, 1'b1, 8'd0);
        // nearest without exact hit, tie and exclusion of the winner
        send_word(FUNC_QUERY, 8'd0,   24'hfa0578, 1'b0, 8'd0);
        send_word(FUNC_QUERY, 8'd0,   24'hfa0578, 1'b1, 8'd128);
        send_word(FUNC_QUERY, 8'd0,   24'h0b151f, 1'b0, 8'd255);
        send_word(FUNC_QUERY, 8'd0,   24'h0b151f, 1'b1, 8'd255);
        send_word(FUNC_WRITE, 8'd255, 24'h000000, 1'b0, 8'd0);
        send_word(FUNC_QUERY, 8'd0,   24'h000000, 1'b0, 8'd255);
        send_word(FUNC_QUERY, 8'd0,   24'h050505, 1'b1, 8'd255);
        send_word(FUNC_WRITE, 8'd1,   24'h00ff00, 1'b1, 8'd1);
        send_word(FUNC_QUERY, 8'd255, 24'h10f010, 1'b0, 8'd1);

        random_words(RANDOM_WORDS);
        phase_no      <= 1;
        send_idle_pct = 70;
        random_words(RANDOM_WORDS);
        phase_no      <= 2;
        send_idle_pct = 0;
        random_words(RANDOM_WORDS);
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (matches_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && matches_owed == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
